/* rtl/stxfr_pkg.sv */
package stxfr_pkg;

    // request codes
    localparam logic [1:0] REQ_BYTE  = 2'd0;
    localparam logic [1:0] REQ_REARM = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    // framing bytes
    localparam logic [7:0] BYTE_STX = 8'h02;
    localparam logic [7:0] BYTE_CR  = 8'h0D;
    localparam logic [7:0] BYTE_LF  = 8'h0A;

    // status of one transaction, taken after the update
    typedef struct packed {
        logic       frame_complete;
        logic       end_pending;
        logic [7:0] frame_length;
        logic       rd_hit;
    } t_status;

endpackage

/* rtl/stxfr_if.sv */
// request channel
interface stxfr_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] rx_byte;
    logic [7:0] read_index;

    modport source (output valid, output req_type, output rx_byte, output read_index,
                    input ready);
    modport sink   (input valid, input req_type, input rx_byte, input read_index,
                    output ready);
endinterface

// response channel
interface stxfr_rsp_if;
    logic       valid;
    logic       ready;
    logic       frame_complete;
    logic       end_pending;
    logic [7:0] frame_length;
    logic [7:0] read_byte;

    modport source (output valid, output frame_complete, output end_pending,
                    output frame_length, output read_byte, input ready);
    modport sink   (input valid, input frame_complete, input end_pending,
                    input frame_length, input read_byte, output ready);
endinterface

/* rtl/stxfr_ram.sv */
module stxfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // single write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read, holds when not enabled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/stxfr_ctrl.sv */
module stxfr_ctrl #(
    parameter int BUFFER_DEPTH = 256
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_accept,
    input  logic [1:0]                      i_req_type,
    input  logic [7:0]                      i_rx_byte,
    input  logic [7:0]                      i_read_index,
    output stxfr_pkg::t_status              o_status,
    output logic                            o_wr_en,
    output logic [$clog2(BUFFER_DEPTH)-1:0] o_wr_addr,
    output logic [7:0]                      o_wr_data,
    output logic                            o_rd_en,
    output logic [$clog2(BUFFER_DEPTH)-1:0] o_rd_addr
);

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int CW = (AW > 8) ? AW : 8;
    localparam logic [AW-1:0] LAST = AW'(BUFFER_DEPTH - 1);

    logic [AW-1:0] r_fill;
    logic [AW-1:0] n_fill;
    logic          r_cr;
    logic          n_cr;
    logic          r_done;
    logic          n_done;
    logic          store;
    logic          rd_hit;

    // next frame state and store decision
    always_comb begin
        n_fill = r_fill;
        n_cr   = r_cr;
        n_done = r_done;
        store  = 1'b0;
        rd_hit = 1'b0;
        if (i_accept) begin
            case (i_req_type)
                stxfr_pkg::REQ_BYTE: begin
                    if (!r_done) begin
                        if (r_cr) begin
                            if (i_rx_byte == stxfr_pkg::BYTE_LF) begin
                                n_done = 1'b1;
                            end
                        end else if (i_rx_byte == stxfr_pkg::BYTE_CR) begin
                            n_cr = 1'b1;
                        end else if (i_rx_byte == stxfr_pkg::BYTE_STX) begin
                            n_fill = '0;
                        end else begin
                            store  = 1'b1;
                            n_fill = (r_fill == LAST) ? '0 : r_fill + 1'b1;
                        end
                    end
                end
                stxfr_pkg::REQ_REARM: begin
                    n_fill = '0;
                    n_cr   = 1'b0;
                    n_done = 1'b0;
                end
                stxfr_pkg::REQ_READ: begin
                    rd_hit = CW'(i_read_index) < CW'(r_fill);
                end
                default: begin
                end
            endcase
        end
    end

    // frame state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_cr   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_fill <= n_fill;
            r_cr   <= n_cr;
            r_done <= n_done;
        end
    end

    // memory commands; a write and a read never touch the store in the same cycle
    assign o_wr_en   = store;
    assign o_wr_addr = r_fill;
    assign o_wr_data = i_rx_byte;
    assign o_rd_en   = rd_hit;
    assign o_rd_addr = AW'(i_read_index);

    assign o_status.frame_complete = n_done;
    assign o_status.end_pending    = n_cr;
    assign o_status.frame_length   = 8'(n_fill);
    assign o_status.rd_hit         = rd_hit;

    // no store once the frame is complete or an end is pending
    a_no_store_when_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr_en |-> (!r_done && !r_cr))
        else $error("payload write while frame closed");

    // length always stays below the buffer depth
    a_fill_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= LAST)
        else $error("fill count beyond buffer depth");

    // rearm clears the frame on the next cycle
    a_rearm_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_req_type == stxfr_pkg::REQ_REARM) |=>
        (r_fill == '0 && !r_cr && !r_done))
        else $error("rearm did not clear frame");

    // a hit read addresses a stored entry
    a_hit_below_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rd_en |-> (o_rd_addr < r_fill && !o_wr_en))
        else $error("read beyond fill count");

endmodule

/* rtl/stx_crlf_frame_receiver_top.sv */
// channel   direction  payload                                            accepted when
// i_req     in         req_type, rx_byte, read_index                      valid && ready
// o_rsp     out        frame_complete, end_pending, frame_length, read_byte  valid && ready
//
// one request per cycle unless stalled; each gives one response via the read and output registers
// the payload store is a BUFFER_DEPTH x 8 ram with one write and one registered read port
// frame state lives in registers and is updated in the accept cycle
// reset is synchronous active low; the payload store has no reset and no clearing pass
// a stalled response holds the read stage; the request side stalls only when both stages are full
module stx_crlf_frame_receiver_top #(
    parameter int BUFFER_DEPTH = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    stxfr_req_if.sink          i_req,
    stxfr_rsp_if.source        o_rsp
);

    localparam int AW = $clog2(BUFFER_DEPTH);

    stxfr_pkg::t_status status;
    stxfr_pkg::t_status r_s1_stat;
    stxfr_pkg::t_status r_out_stat;
    logic               r_s1_valid;
    logic               r_out_valid;
    logic [7:0]         r_out_byte;
    logic               s1_adv;
    logic               accept;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [7:0]         wr_data;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic [7:0]         rd_data;

    // handshake
    assign s1_adv      = !r_out_valid || o_rsp.ready;
    assign i_req.ready = !r_s1_valid || s1_adv;
    assign accept      = i_req.valid && i_req.ready;

    stxfr_ctrl #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_req_type   (i_req.req_type),
        .i_rx_byte    (i_req.rx_byte),
        .i_read_index (i_req.read_index),
        .o_status     (status),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data),
        .o_rd_en      (rd_en),
        .o_rd_addr    (rd_addr)
    );

    stxfr_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // read stage: status waits for ram data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_stat <= status;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_valid) begin
            r_out_stat <= r_s1_stat;
            r_out_byte <= r_s1_stat.rd_hit ? rd_data : 8'h00;
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.frame_complete = r_out_stat.frame_complete;
    assign o_rsp.end_pending    = r_out_stat.end_pending;
    assign o_rsp.frame_length   = r_out_stat.frame_length;
    assign o_rsp.read_byte      = r_out_byte;

    // a held response is not replaced
    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_rsp.ready) |=> (r_out_valid && $stable(r_out_byte)))
        else $error("stalled response changed");

    // no request taken while both stages are blocked
    a_no_accept_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && !o_rsp.ready) |-> !accept)
        else $error("request accepted while pipeline full");

    // ram read data is not disturbed while the read stage waits
    a_no_read_while_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_adv) |-> !rd_en)
        else $error("ram read while read stage stalled");

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps

module testbench;

    localparam int         DEPTH        = 256;
    localparam logic [1:0] REQ_UNUSED   = 2'd3;
    localparam int         RANDOM_ITEMS = 1650;
    localparam int         HOLD_CYCLES  = 120;
    localparam int         DRAIN_CYCLES = 10;
    localparam int         CYCLE_LIMIT  = 600000;

    // one response as seen on the output channel
    typedef struct packed {
        logic       frame_complete;
        logic       end_pending;
        logic [7:0] frame_length;
        logic [7:0] read_byte;
    } t_frame_status;

    // tracks the frame state and holds the statuses still owed by the block
    class frame_scoreboard;
        logic [7:0]    payload [DEPTH];
        int            fill;
        bit            cr_seen;
        bit            frame_done;
        t_frame_status expected_status [$];
        int            mismatch_count;

        function new();
            fill           = 0;
            cr_seen        = 1'b0;
            frame_done     = 1'b0;
            mismatch_count = 0;
        endfunction

        task report_mismatch(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            mismatch_count++;
        endtask

        function int pending();
            return expected_status.size();
        endfunction

        // received byte: CR and LF steer the flags, STX restarts the length, others go to the store until a CR
        function void take_byte(logic [7:0] b);
            if (frame_done) return;
            if (cr_seen) begin
                if (b == stxfr_pkg::BYTE_LF) frame_done = 1'b1;
                return;
            end
            if (b == stxfr_pkg::BYTE_CR) begin
                cr_seen = 1'b1;
            end else if (b == stxfr_pkg::BYTE_STX) begin
                fill = 0;
            end else begin
                payload[fill] = b;
                fill++;
                if (fill >= DEPTH) fill = 0;
            end
        endfunction

        // accepted request: update the frame and queue the status it gives
        function void note_request(logic [1:0] req, logic [7:0] rx, logic [7:0] idx);
            t_frame_status st;
            st.read_byte = 8'h00;
            case (req)
                stxfr_pkg::REQ_BYTE: take_byte(rx);
                stxfr_pkg::REQ_REARM: begin
                    fill       = 0;
                    cr_seen    = 1'b0;
                    frame_done = 1'b0;
                end
                stxfr_pkg::REQ_READ: begin
                    if (int'(idx) < fill) st.read_byte = payload[idx];
                end
                default: ;
            endcase
            st.frame_complete = frame_done;
            st.end_pending    = cr_seen;
            st.frame_length   = fill[7:0];
            expected_status.push_back(st);
        endfunction

        // accepted response against the oldest expectation
        task check_status(t_frame_status got);
            t_frame_status want;
            if (expected_status.size() == 0) begin
                report_mismatch($sformatf("response with nothing expected, length %0d",
                                          got.frame_length));
                return;
            end
            want = expected_status.pop_front();
            if (got.frame_complete !== want.frame_complete)
                report_mismatch($sformatf("frame_complete %b, want %b",
                                          got.frame_complete, want.frame_complete));
            if (got.end_pending !== want.end_pending)
                report_mismatch($sformatf("end_pending %b, want %b",
                                          got.end_pending, want.end_pending));
            if (got.frame_length !== want.frame_length)
                report_mismatch($sformatf("frame_length %0d, want %0d",
                                          got.frame_length, want.frame_length));
            if (got.read_byte !== want.read_byte)
                report_mismatch($sformatf("read_byte %h, want %h",
                                          got.read_byte, want.read_byte));
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    stxfr_req_if req_if ();
    stxfr_rsp_if rsp_if ();

    frame_scoreboard status_board;
    int              items_sent;
    int              cycle_count;
    bit              no_gaps;
    bit              hold_request;
    bit              hold_active;

    stx_crlf_frame_receiver_top #(
        .BUFFER_DEPTH(DEPTH)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // clock
    always #10 i_clk = ~i_clk;

    // sender gap length: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        if (no_gaps) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // payload byte that never acts as a framing byte
    function automatic logic [7:0] payload_byte();
        logic [7:0] b;
        b = 8'($urandom);
        if (b == stxfr_pkg::BYTE_CR || b == stxfr_pkg::BYTE_STX) b = b ^ 8'h80;
        return b;
    endfunction

    // read index mostly inside the stored length, sometimes past it
    function automatic logic [7:0] read_near_fill();
        int hi;
        if ($urandom_range(0, 9) == 0) return 8'($urandom);
        hi = status_board.fill + 1;
        if (hi > 255) hi = 255;
        return 8'($urandom_range(0, hi));
    endfunction

    // one request transaction, waits for acceptance
    task automatic send_item(input logic [1:0] req, input logic [7:0] rx,
                             input logic [7:0] idx);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid      <= 1'b1;
        req_if.req_type   <= req;
        req_if.rx_byte    <= rx;
        req_if.read_index <= idx;
        do @(posedge i_clk); while (!req_if.ready);
        status_board.note_request(req, rx, idx);
        items_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(stxfr_pkg::REQ_BYTE, b, 8'($urandom));
    endtask

    task automatic send_read(input logic [7:0] idx);
        send_item(stxfr_pkg::REQ_READ, 8'($urandom), idx);
    endtask

    task automatic send_rearm();
        send_item(stxfr_pkg::REQ_REARM, 8'($urandom), 8'($urandom));
    endtask

    task automatic send_noise();
        send_item(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom));
    endtask

    // rearm, payload with reads in between, CR and usually LF, then reads of the frame
    task automatic send_frame(input int len);
        bit stx_inside;
        bit junk_after_cr;
        bit drop_lf;
        int n;
        stx_inside    = ($urandom_range(0, 6) == 0);
        junk_after_cr = ($urandom_range(0, 9) == 0);
        drop_lf       = ($urandom_range(0, 9) == 0);
        send_rearm();
        if ($urandom_range(0, 2) == 0) send_byte(stxfr_pkg::BYTE_STX);
        for (int i = 0; i < len; i++) begin
            if (stx_inside && i == len / 2) send_byte(stxfr_pkg::BYTE_STX);
            send_byte(payload_byte());
            if ($urandom_range(0, 4) == 0) send_read(read_near_fill());
        end
        send_byte(stxfr_pkg::BYTE_CR);
        if (junk_after_cr) begin
            n = $urandom_range(1, 3);
            repeat (n) send_byte(8'($urandom));
        end
        if (!drop_lf) send_byte(stxfr_pkg::BYTE_LF);
        n = $urandom_range(0, 3);
        repeat (n) send_read(read_near_fill());
        if ($urandom_range(0, 3) == 0) send_byte(8'($urandom));
    endtask

    // long output hold while requests keep coming
    task automatic pressure_burst();
        no_gaps      = 1'b1;
        hold_request = 1'b1;
        // the last transaction is already taken, so stop offering it
        if (req_if.valid) req_if.valid <= 1'b0;
        @(posedge i_clk);
        wait (hold_active);
        send_rearm();
        repeat (30) begin
            send_byte(payload_byte());
            if ($urandom_range(0, 3) == 0) send_read(read_near_fill());
        end
        no_gaps = 1'b0;
    endtask

    // sender waits for every owed response
    task automatic drain_pause();
        req_if.valid <= 1'b0;
        do @(posedge i_clk); while (status_board.pending() != 0);
    endtask

    // response side: random ready pattern, long hold on request
    initial begin
        bit lvl;
        int span;
        int r;
        rsp_if.ready = 1'b0;
        hold_active  = 1'b0;
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                hold_active  = 1'b1;
                lvl          = 1'b0;
                span         = HOLD_CYCLES;
            end else begin
                hold_active = 1'b0;
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    lvl  = 1'b1;
                    span = $urandom_range(1, 20);
                end else if (r < 95) begin
                    lvl  = 1'b0;
                    span = $urandom_range(1, 3);
                end else begin
                    lvl  = 1'b0;
                    span = $urandom_range(10, 40);
                end
            end
            rsp_if.ready <= lvl;
            repeat (span) @(posedge i_clk);
        end
    end

    // response monitor
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready)
            status_board.check_status('{rsp_if.frame_complete, rsp_if.end_pending,
                                        rsp_if.frame_length, rsp_if.read_byte});
    end

    // run limit
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAIL stx_crlf_frame_receiver_top");
        $finish;
    end

    // stimulus
    initial begin
        int r;
        int target;
        status_board      = new();
        items_sent        = 0;
        no_gaps           = 1'b0;
        hold_request      = 1'b0;
        i_clk             = 1'b0;
        i_rst_n           = 1'b0;
        req_if.valid      = 1'b0;
        req_if.req_type   = stxfr_pkg::REQ_BYTE;
        req_if.rx_byte    = 8'h00;
        req_if.read_index = 8'h00;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, framing bytes, ignored bytes, reads past the length
        send_read(8'd0);
        send_rearm();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h41);
        send_read(8'd1);
        send_read(8'd2);
        send_read(8'd3);
        send_read(8'd255);
        send_byte(stxfr_pkg::BYTE_STX);
        send_byte(8'h55);
        send_byte(stxfr_pkg::BYTE_CR);
        send_byte(8'h30);
        send_byte(stxfr_pkg::BYTE_STX);
        send_byte(stxfr_pkg::BYTE_CR);
        send_byte(stxfr_pkg::BYTE_LF);
        send_byte(8'h61);
        send_byte(stxfr_pkg::BYTE_CR);
        send_read(8'd0);
        send_item(REQ_UNUSED, 8'hFF, 8'hFF);
        send_rearm();
        send_read(8'd0);

        // random part, opening with a frame long enough to wrap the store
        target = items_sent + RANDOM_ITEMS;
        send_frame(DEPTH + 4);
        pressure_burst();
        drain_pause();
        while (items_sent < target) begin
            no_gaps = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 75) begin
                if ($urandom_range(0, 99) == 0)
                    send_frame($urandom_range(200, 300));
                else
                    send_frame($urandom_range(0, 24));
            end else if (r < 90) begin
                repeat ($urandom_range(1, 8)) send_noise();
            end else if (r < 96) begin
                drain_pause();
            end else begin
                pressure_burst();
            end
        end
        req_if.valid <= 1'b0;

        while (status_board.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (status_board.mismatch_count == 0)
            $display("PASS stx_crlf_frame_receiver_top");
        else
            $display("FAIL stx_crlf_frame_receiver_top");
        $finish;
    end

endmodule

/* sim.f */
rtl/stxfr_pkg.sv
rtl/stxfr_if.sv
rtl/stxfr_ram.sv
rtl/stxfr_ctrl.sv
rtl/stx_crlf_frame_receiver_top.sv
tb/sv/testbench.sv
